### rtl/palette_delta_decoder_macros.svh
// ----------------------------------------------------------------------------
// palette_delta_decoder_macros.svh
// Assertion macros shared by the palette delta decoder.
// ----------------------------------------------------------------------------
`ifndef PALETTE_DELTA_DECODER_MACROS_SVH
`define PALETTE_DELTA_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PDD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("palette delta decoder: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PDD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("palette delta decoder: next-cycle check failed");

`endif

### rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// Types, constants and the component expansion shared by the palette decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pdd_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int SlotW           = 8;
    localparam int Slots           = 1 << SlotW;
    localparam int CompW           = 8;
    localparam int RgbW            = 3 * CompW;
    localparam int EntW            = $clog2(PALETTE_ENTRIES + 1);
    localparam int LenW            = 10;
    localparam int RunW            = 8;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        PH_LENGTH  = 3'd0,
        PH_COMMAND = 3'd1,
        PH_SOURCE  = 3'd2,
        PH_SECOND  = 3'd3,
        PH_THIRD   = 3'd4,
        PH_PADDING = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'd0,
        ST_IDLE  = 3'd1,
        ST_READ  = 3'd2,
        ST_BYTE  = 3'd3,
        ST_RUN   = 3'd4,
        ST_CHECK = 3'd5,
        ST_EMIT  = 3'd6
    } t_state;

    typedef struct packed {
        logic             we0;
        logic             we1;
        logic [SlotW-1:0] waddr;
        logic [RgbW-1:0]  wdata;
        logic [SlotW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic [RgbW-1:0] rgb;
        logic            complete;
        logic            cend;
    } t_result;

    function automatic logic [CompW-1:0] expand6(input logic [5:0] x);
        return {x, x[5:4]};
    endfunction

endpackage

`default_nettype wire

### rtl/pdd_bank_ram.sv
// ----------------------------------------------------------------------------
// pdd_bank_ram
// One palette bank: single write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_bank_ram
    import pdd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [SlotW-1:0] i_waddr,
    input  wire logic [RgbW-1:0]  i_wdata,
    input  wire logic [SlotW-1:0] i_raddr,
    output logic      [RgbW-1:0]  o_rdata
);

    logic [RgbW-1:0] r_mem [Slots];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/pdd_ctrl.sv
// ----------------------------------------------------------------------------
// pdd_ctrl
// Chunk parser and run sequencer. Reads the old bank, writes the new bank.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_ctrl
    import pdd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_operation,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [SlotW-1:0] i_entry_index,
    output t_ram_req              o_ram,
    input  wire logic [RgbW-1:0]  i_rdata0,
    input  wire logic [RgbW-1:0]  i_rdata1,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  wire logic             i_res_ready
);

    localparam logic [EntW-1:0] NEntries = EntW'(PALETTE_ENTRIES);

    t_state            r_state,     n_state;
    t_phase            r_phase,     n_phase;
    logic              r_bank,      n_bank;
    logic [EntW-1:0]   r_entry_cnt, n_entry_cnt;
    logic [LenW-1:0]   r_seen,      n_seen;
    logic [LenW-1:0]   r_len,       n_len;
    logic [5:0]        r_pending,   n_pending;
    logic [15:0]       r_partial,   n_partial;
    logic [SlotW-1:0]  r_clr,       n_clr;
    logic [RunW-1:0]   r_left,      n_left;
    logic [EntW-1:0]   r_issue,     n_issue;
    logic              r_rd_pend,   n_rd_pend;
    logic              r_complete,  n_complete;
    logic              r_cend,      n_cend;
    logic [7:0]        r_byte,      n_byte;
    logic [SlotW-1:0]  r_src,       n_src;
    logic [RgbW-1:0]   r_rgb,       n_rgb;

    logic              accept;
    logic              run_issue;
    logic              run_start;
    logic [RgbW-1:0]   old_data;
    logic [CompW-1:0]  byte_comp;

    assign accept    = i_in_valid && o_in_ready;
    assign run_issue = (r_left != '0) && (r_issue < NEntries);
    assign run_start = ((r_phase == PH_COMMAND) && r_byte[7]) || (r_phase == PH_SOURCE);
    assign old_data  = r_bank ? i_rdata1 : i_rdata0;
    assign byte_comp = expand6(r_byte[5:0]);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == SlotW'(Slots - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_operation == OP_READ) ? ST_READ : ST_BYTE;
                end
            end
            ST_READ:  n_state = ST_EMIT;
            ST_BYTE:  n_state = run_start ? ST_RUN : ST_CHECK;
            ST_RUN: begin
                if (!run_issue && !r_rd_pend) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_bank      = r_bank;
        n_entry_cnt = r_entry_cnt;
        n_seen      = r_seen;
        n_len       = r_len;
        n_pending   = r_pending;
        n_partial   = r_partial;
        n_clr       = r_clr;
        n_left      = r_left;
        n_issue     = r_issue;
        n_rd_pend   = 1'b0;
        n_complete  = r_complete;
        n_cend      = r_cend;
        n_byte      = r_byte;
        n_src       = r_src;
        n_rgb       = r_rgb;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram.we0   = 1'b0;
        o_ram.we1   = 1'b0;
        o_ram.waddr = SlotW'(r_entry_cnt);
        o_ram.wdata = '0;
        o_ram.raddr = i_entry_index;

        unique case (r_state)
            ST_CLEAR: begin
                o_ram.we0   = 1'b1;
                o_ram.we1   = 1'b1;
                o_ram.waddr = r_clr;
                n_clr       = r_clr + 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_byte     = i_data_byte;
                    n_rgb      = '0;
                    n_complete = 1'b0;
                    n_cend     = 1'b0;
                end
            end
            ST_READ: begin
                n_rgb = old_data;
            end
            ST_BYTE: begin
                n_seen = (r_seen == '1) ? r_seen : r_seen + 1'b1;
                unique case (r_phase)
                    PH_COMMAND: begin
                        if (r_byte[7]) begin
                            n_left  = RunW'(r_byte[6:0]) + 1'b1;
                            n_src   = SlotW'(r_entry_cnt);
                            n_issue = r_entry_cnt;
                        end else if (r_byte[6]) begin
                            n_pending = r_byte[5:0];
                            n_phase   = PH_SOURCE;
                        end else begin
                            n_partial = {byte_comp, 8'h00};
                            n_phase   = PH_SECOND;
                        end
                    end
                    PH_SOURCE: begin
                        n_left  = RunW'(r_pending) + 1'b1;
                        n_src   = r_byte;
                        n_issue = r_entry_cnt;
                        n_phase = PH_COMMAND;
                    end
                    PH_SECOND: begin
                        n_partial = {r_partial[15:8], byte_comp};
                        n_phase   = PH_THIRD;
                    end
                    PH_THIRD: begin
                        if (r_entry_cnt < NEntries) begin
                            o_ram.we0   = r_bank;
                            o_ram.we1   = !r_bank;
                            o_ram.wdata = {r_partial, byte_comp};
                            n_entry_cnt = r_entry_cnt + 1'b1;
                        end
                        n_phase = PH_COMMAND;
                    end
                    PH_PADDING: begin
                        if (n_seen >= r_len) begin
                            n_cend  = 1'b1;
                            n_phase = PH_LENGTH;
                        end
                    end
                    PH_LENGTH: begin
                        n_len       = {r_byte, 2'b00};
                        n_seen      = LenW'(1);
                        n_entry_cnt = '0;
                        n_phase     = PH_COMMAND;
                    end
                    default: begin
                        n_phase = PH_LENGTH;
                    end
                endcase
            end
            ST_RUN: begin
                o_ram.raddr = r_src;
                if (run_issue) begin
                    n_src     = r_src + 1'b1;
                    n_left    = r_left - 1'b1;
                    n_issue   = r_issue + 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    o_ram.we0   = r_bank;
                    o_ram.we1   = !r_bank;
                    o_ram.wdata = old_data;
                    n_entry_cnt = r_entry_cnt + 1'b1;
                end
            end
            ST_CHECK: begin
                if ((r_phase == PH_COMMAND) && (r_entry_cnt >= NEntries)) begin
                    n_complete = 1'b1;
                    n_bank     = !r_bank;
                    if (r_seen >= r_len) begin
                        n_cend  = 1'b1;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_phase = PH_PADDING;
                    end
                end
            end
            ST_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    assign o_res.rgb      = r_rgb;
    assign o_res.complete = r_complete;
    assign o_res.cend     = r_cend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_LENGTH;
            r_bank      <= 1'b0;
            r_entry_cnt <= '0;
            r_seen      <= '0;
            r_len       <= '0;
            r_pending   <= '0;
            r_partial   <= '0;
            r_clr       <= '0;
            r_left      <= '0;
            r_issue     <= '0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bank      <= n_bank;
            r_entry_cnt <= n_entry_cnt;
            r_seen      <= n_seen;
            r_len       <= n_len;
            r_pending   <= n_pending;
            r_partial   <= n_partial;
            r_clr       <= n_clr;
            r_left      <= n_left;
            r_issue     <= n_issue;
            r_rd_pend   <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_complete <= n_complete;
        r_cend     <= n_cend;
        r_byte     <= n_byte;
        r_src      <= n_src;
        r_rgb      <= n_rgb;
    end

endmodule

`default_nettype wire

### rtl/palette_delta_decoder.sv
// ----------------------------------------------------------------------------
// palette_delta_decoder
// Rebuilds a 256-entry RGB palette from delta-coded palette chunk bytes.
// ----------------------------------------------------------------------------
// After reset the block clears all 256 entries of both palette banks, one
// entry per cycle; input ready stays low during that pass. Each request then
// gives one result. A palette read passes through the read and emit states,
// and a plain chunk byte through the byte, check and emit states; a keep or
// copy command moves its entries through the bank memories one entry per
// cycle, so such a byte passes through the byte, run, check and emit states.
// The old palette is read from one bank while the new one is written to the
// other, and the banks swap when the new palette is complete. A finished
// result waits in the output register while the next request is accepted.
`default_nettype none

`include "palette_delta_decoder_macros.svh"

module palette_delta_decoder
    import pdd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic             i_operation,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic [SlotW-1:0] i_entry_index,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic      [CompW-1:0] o_red_out,
    output logic      [CompW-1:0] o_green_out,
    output logic      [CompW-1:0] o_blue_out,
    output logic                  o_palette_complete,
    output logic                  o_chunk_end
);

    t_ram_req        w_ram;
    logic [RgbW-1:0] w_rdata0;
    logic [RgbW-1:0] w_rdata1;
    logic            w_res_valid;
    logic            w_res_ready;
    t_result         w_res;
    t_result         r_out;
    logic            r_out_valid;
    logic            w_has_rgb;
    logic            w_has_flag;

    pdd_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_data_byte   (i_data_byte),
        .i_entry_index (i_entry_index),
        .o_ram         (w_ram),
        .i_rdata0      (w_rdata0),
        .i_rdata1      (w_rdata1),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res),
        .i_res_ready   (w_res_ready)
    );

    pdd_bank_ram u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_ram.we0),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata0)
    );

    pdd_bank_ram u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_ram.we1),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata1)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_red_out          = r_out.rgb[RgbW-1 -: CompW];
    assign o_green_out        = r_out.rgb[CompW +: CompW];
    assign o_blue_out         = r_out.rgb[CompW-1:0];
    assign o_palette_complete = r_out.complete;
    assign o_chunk_end        = r_out.cend;

    assign w_has_rgb  = |r_out.rgb;
    assign w_has_flag = r_out.complete || r_out.cend;

    // A result that carries color came from a read and never flags the chunk.
    `PDD_ASSERT_IMPLY(a_read_no_flags, o_out_valid && w_has_rgb, !w_has_flag)

    // The parser never takes a request while it is offering a result.
    `PDD_ASSERT_IMPLY(a_ready_excl_result, o_in_ready, !w_res_valid)

    // Both banks are written together only by the clearing pass.
    `PDD_ASSERT_IMPLY(a_dual_write_clear, w_ram.we0 && w_ram.we1, w_ram.wdata == '0)

    // A result offered but not taken is still offered in the next cycle.
    `PDD_ASSERT_NEXT(a_result_held, w_res_valid && !w_res_ready, w_res_valid)

endmodule

`default_nettype wire
